// ===== src/fqd_pkg.sv =====
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared types and constants for the FIFO queue with delete-by-value block.
// ----------------------------------------------------------------------------
package fqd_pkg;

   // Queue geometry. DEPTH is a power of two so that slot arithmetic wraps.
   localparam int DEPTH        = 16;
   localparam int HANDLE_WIDTH = 32;
   localparam int IDX_W        = $clog2(DEPTH);
   localparam int CNT_W        = $clog2(DEPTH + 1);

   // Command queue between the front and the back.
   localparam int CQ_DEPTH = 2;
   localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

   // Operation codes carried by an input item.
   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_DELETE  = 2'd2,
      OP_ITERATE = 2'd3
   } op_type;

   // Command kinds after classification by the front.
   typedef enum logic [2:0] {
      CMD_ENQUEUE,
      CMD_DEQUEUE,
      CMD_DELETE,
      CMD_ITERATE,
      CMD_REJECT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [HANDLE_WIDTH-1:0] handle;
   } cmd_type;

   // Result status codes.
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // Sequencer states of the back.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEQUEUE,
      ST_SEARCH,
      ST_SHIFT,
      ST_ITERATE
   } state_type;

   typedef struct packed {
      logic                    status;
      logic                    item_valid;
      logic [HANDLE_WIDTH-1:0] handle_out;
      logic [CNT_W-1:0]        length;
      logic                    last;
   } rsp_type;

endpackage

// ===== src/fqd_if.sv =====
// ----------------------------------------------------------------------------
// fqd_req_if / fqd_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface fqd_req_if import fqd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              operation;
   logic [HANDLE_WIDTH-1:0] handle;

   modport source(output valid, operation, handle, input ready);
   modport sink(input valid, operation, handle, output ready);
endinterface

interface fqd_rsp_if import fqd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    status;
   logic                    item_valid;
   logic [HANDLE_WIDTH-1:0] handle_out;
   logic [CNT_W-1:0]        length;
   logic                    last;

   modport source(output valid, status, item_valid, handle_out, length, last, input ready);
   modport sink(input valid, status, item_valid, handle_out, length, last, output ready);
endinterface

// ===== src/fifo_queue_with_delete_top.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_top
// Bounded FIFO of nonzero handles with dequeue, delete by value and iterate.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries an operation code and a handle. The result
// channel returns status, item_valid, handle_out, the queue length after the
// operation and a last flag on the final result of each request item.
// Requests go into a two-entry command queue; the back then executes them.
// Enqueue and rejected items pass through a command queue entry and then the
// result register; dequeue also passes through the registered store read.
// Delete walks the stored entries one per cycle through the single read port
// of the handle store and moves the following entries down one per cycle.
// Iterate returns one result per cycle while the receiver takes them, after a
// registered store read; a run of 16 results is the worst case.
// Reset empties the queue and the command queue; the store needs no clearing.
// When the receiver stalls, the result register holds its item, the back
// waits, and the request side keeps accepting until the command queue fills.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete_top import fqd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   fqd_req_if.sink   req_ch,
   fqd_rsp_if.source rsp_ch
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   // Front: classification and command queue.
   fqd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   // Back: store, sequencer and result register.
   fqd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== src/fqd_front.sv =====
// ----------------------------------------------------------------------------
// fqd_front
// Accepts request items, classifies them and holds them in a short command
// queue until the back takes them.
// ----------------------------------------------------------------------------
module fqd_front import fqd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   fqd_req_if.sink    req_ch,
   output cmd_type    cmd,
   output logic       cmd_valid,
   input  logic       cmd_pop
);

   cmd_type               queue_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_W-1:0]   fill_ff, fill_in;
   cmd_type               classified;
   logic                  push;
   logic                  pop;

   // Decode the operation; a zero handle on enqueue or delete is rejected here.
   always_comb begin
      classified.handle = req_ch.handle;
      unique case (op_type'(req_ch.operation))
         OP_ENQUEUE: classified.kind = (req_ch.handle == '0) ? CMD_REJECT : CMD_ENQUEUE;
         OP_DEQUEUE: classified.kind = CMD_DEQUEUE;
         OP_DELETE:  classified.kind = (req_ch.handle == '0) ? CMD_REJECT : CMD_DELETE;
         OP_ITERATE: classified.kind = CMD_ITERATE;
         default:    classified.kind = CMD_REJECT;
      endcase
   end

   assign req_ch.ready = (fill_ff != CQ_CNT_W'(CQ_DEPTH));
   assign cmd_valid    = (fill_ff != '0);
   assign cmd          = queue_ff[rd_ptr_ff];
   assign push         = req_ch.valid && req_ch.ready;
   assign pop          = cmd_pop && cmd_valid;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Command storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ===== src/fqd_back.sv =====
// ----------------------------------------------------------------------------
// fqd_back
// Carries out queued commands against the handle store and drives the
// result register.
// ----------------------------------------------------------------------------
module fqd_back import fqd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic       cmd_valid,
   output logic       cmd_pop,
   fqd_rsp_if.source  rsp_ch
);

   logic [HANDLE_WIDTH-1:0] mem [DEPTH];
   logic [HANDLE_WIDTH-1:0] rd_data_ff;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic [HANDLE_WIDTH-1:0] key_ff, key_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic [HANDLE_WIDTH-1:0] mem_wdata;
   logic                    mem_re;
   logic [IDX_W-1:0]        mem_raddr;

   logic                    out_free;
   logic [CNT_W-1:0]        pos_next;
   logic [CNT_W-1:0]        pos_prev;
   logic                    more;
   logic                    hit;

   // Physical slot of a queue position.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] pos);
      return head + pos[IDX_W-1:0];
   endfunction

   function automatic rsp_type make_rsp(input logic status, input logic item_valid,
                                        input logic [HANDLE_WIDTH-1:0] handle_out,
                                        input logic [CNT_W-1:0] length,
                                        input logic last);
      rsp_type r;
      r.status     = status;
      r.item_valid = item_valid;
      r.handle_out = handle_out;
      r.length     = length;
      r.last       = last;
      return r;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign pos_next = pos_ff + 1'b1;
   assign pos_prev = pos_ff - 1'b1;
   assign more     = (pos_next < count_ff);
   assign hit      = (rd_data_ff == key_ff);

   // Sequencer: next state, store accesses and result generation.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = slot_of(head_ff, pos_prev);
      mem_wdata    = rd_data_ff;
      mem_re       = 1'b0;
      mem_raddr    = slot_of(head_ff, pos_next);
      cmd_pop      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(STATUS_REJECT, 1'b0, '0, count_ff, 1'b1);
               unique case (cmd.kind)
                  CMD_ENQUEUE: begin
                     if (count_ff != CNT_W'(DEPTH)) begin
                        mem_we    = 1'b1;
                        mem_waddr = slot_of(head_ff, count_ff);
                        mem_wdata = cmd.handle;
                        count_in  = count_ff + 1'b1;
                        rsp_in    = make_rsp(STATUS_OK, 1'b0, '0, count_ff + 1'b1, 1'b1);
                     end
                  end
                  CMD_DEQUEUE: begin
                     if (count_ff != '0) begin
                        rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
                        rsp_in       = rsp_ff;
                        mem_re       = 1'b1;
                        mem_raddr    = head_ff;
                        state_in     = ST_DEQUEUE;
                     end
                  end
                  CMD_DELETE, CMD_ITERATE: begin
                     if (count_ff != '0) begin
                        rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
                        rsp_in       = rsp_ff;
                        mem_re       = 1'b1;
                        mem_raddr    = head_ff;
                        pos_in       = '0;
                        key_in       = cmd.handle;
                        state_in     = (cmd.kind == CMD_DELETE) ? ST_SEARCH : ST_ITERATE;
                     end else if (cmd.kind == CMD_ITERATE) begin
                        rsp_in = make_rsp(STATUS_OK, 1'b0, '0, count_ff, 1'b1);
                     end
                  end
                  default: begin
                     // A rejected command keeps the default reject result.
                  end
               endcase
            end
         end

         ST_DEQUEUE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(STATUS_OK, 1'b1, rd_data_ff, count_ff - 1'b1, 1'b1);
               head_in      = head_ff + 1'b1;
               count_in     = count_ff - 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_SEARCH: begin
            if (more) begin
               // Fetch the next entry; on a hit it is the first to move down.
               mem_re   = 1'b1;
               pos_in   = pos_next;
               state_in = hit ? ST_SHIFT : ST_SEARCH;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (hit) begin
                  count_in = count_ff - 1'b1;
                  rsp_in   = make_rsp(STATUS_OK, 1'b0, '0, count_ff - 1'b1, 1'b1);
               end else begin
                  rsp_in   = make_rsp(STATUS_REJECT, 1'b0, '0, count_ff, 1'b1);
               end
            end
         end

         ST_SHIFT: begin
            // The entry at pos moves down one place.
            if (more) begin
               mem_we = 1'b1;
               mem_re = 1'b1;
               pos_in = pos_next;
            end else if (out_free) begin
               mem_we       = 1'b1;
               count_in     = count_ff - 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(STATUS_OK, 1'b0, '0, count_ff - 1'b1, 1'b1);
               state_in     = ST_IDLE;
            end
         end

         ST_ITERATE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(STATUS_OK, 1'b1, rd_data_ff, count_ff, !more);
               if (more) begin
                  mem_re = 1'b1;
                  pos_in = pos_next;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   // Handle store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_ff.status;
   assign rsp_ch.item_valid = rsp_ff.item_valid;
   assign rsp_ch.handle_out = rsp_ff.handle_out;
   assign rsp_ch.length     = rsp_ff.length;
   assign rsp_ch.last       = rsp_ff.last;

endmodule

// ===== src/fqd_checker.sv =====
// ----------------------------------------------------------------------------
// fqd_checker
// Port-level checks on the result channel of the queue block.
// ----------------------------------------------------------------------------
module fqd_checker import fqd_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_status,
   input logic                    rsp_item_valid,
   input logic [HANDLE_WIDTH-1:0] rsp_handle_out,
   input logic [CNT_W-1:0]        rsp_length,
   input logic                    rsp_last
);

   // A stalled result item holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_handle_out)
         && $stable(rsp_length) && $stable(rsp_last) && $stable(rsp_status))
      else $error("result item changed while stalled");

   // The reported length never exceeds the capacity.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_length <= CNT_W'(DEPTH))
      else $error("length above capacity");

   // A rejected request yields one lone result without a handle.
   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_item_valid && rsp_last && rsp_handle_out == '0)
      else $error("malformed reject result");

   // Within an iteration run the length stays constant.
   a_run_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last ##1 rsp_valid |-> $stable(rsp_length)
         || $past(rsp_length) == rsp_length)
      else $error("length changed inside an iteration run");

endmodule

bind fifo_queue_with_delete_top fqd_checker u_fqd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_item_valid (rsp_ch.item_valid),
   .rsp_handle_out (rsp_ch.handle_out),
   .rsp_length     (rsp_ch.length),
   .rsp_last       (rsp_ch.last)
);

// ===== sim/fifo_queue_with_delete_top_test.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_top_test
// Self-checking testbench for the FIFO queue with delete by value.
// A directed pass covers the empty and full queue, zero handles, missing
// handles and deletion at the oldest, middle and newest positions. A long
// random pass follows, made of fill and drain phases. Every accepted request
// item is run through a behavioral copy of the queue, and every result item
// is compared with the oldest expected result. The sender works in bursts
// and the receiver switches between several stall patterns.
// ----------------------------------------------------------------------------
module fifo_queue_with_delete_top_test;
   import fqd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS = 414;
   localparam int POOL_SIZE    = 8;
   localparam int PRINT_LIMIT  = 50;

   // Receiver stall patterns.
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PERIODIC,
      RX_SPARSE
   } rx_pattern_type;

   logic clock = 1'b0;
   logic reset;

   fqd_req_if req_ch();
   fqd_rsp_if rsp_ch();

   fifo_queue_with_delete_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Behavioral copy of the queue contents, oldest first.
   logic [HANDLE_WIDTH-1:0] stored_handles[$];
   // Results still owed by the block, oldest first.
   rsp_type                 expected_results[$];
   logic [HANDLE_WIDTH-1:0] handle_pool[POOL_SIZE];

   int             mismatch_count = 0;
   int             cycle_count    = 0;
   int             burst_left     = 0;
   int             stall_window   = 0;
   rx_pattern_type stall_mode     = RX_ALWAYS;

   // Clock generation: 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Cycle counter and run watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT)
         $display("Mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Apply one accepted request item to the queue copy and record the
   // results it must produce.
   task automatic apply_queue_op(input op_type op, input logic [HANDLE_WIDTH-1:0] h);
      rsp_type r;
      int      found;
      r       = '0;
      r.last  = 1'b1;
      r.status = STATUS_OK;
      found   = -1;
      case (op)
         OP_ENQUEUE: begin
            if (h == '0 || stored_handles.size() >= DEPTH)
               r.status = STATUS_REJECT;
            else
               stored_handles.push_back(h);
         end
         OP_DEQUEUE: begin
            if (stored_handles.size() == 0) begin
               r.status = STATUS_REJECT;
            end else begin
               r.item_valid = 1'b1;
               r.handle_out = stored_handles.pop_front();
            end
         end
         OP_DELETE: begin
            // Only the oldest copy of the handle goes away.
            if (h != '0) begin
               foreach (stored_handles[i])
                  if (found < 0 && stored_handles[i] == h)
                     found = i;
            end
            if (found < 0)
               r.status = STATUS_REJECT;
            else
               stored_handles.delete(found);
         end
         default: begin
            // Iterate: one result per stored handle, or a single empty one.
            foreach (stored_handles[i]) begin
               r.item_valid = 1'b1;
               r.handle_out = stored_handles[i];
               r.length     = CNT_W'(stored_handles.size());
               r.last       = (i == stored_handles.size() - 1);
               expected_results.push_back(r);
            end
         end
      endcase
      if (op != OP_ITERATE || stored_handles.size() == 0) begin
         r.length = CNT_W'(stored_handles.size());
         expected_results.push_back(r);
      end
   endtask

   // Send one request item; bursts of random length are separated by gaps.
   task automatic send_item(input op_type op, input logic [HANDLE_WIDTH-1:0] h);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.handle    <= h;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      apply_queue_op(op, h);
      burst_left--;
   endtask

   // Stop sending and wait until every owed result has arrived.
   task automatic wait_for_results;
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Compare one accepted result item with the oldest expectation.
   task automatic check_result;
      rsp_type got;
      rsp_type want;
      got.status     = rsp_ch.status;
      got.item_valid = rsp_ch.item_valid;
      got.handle_out = rsp_ch.handle_out;
      got.length     = rsp_ch.length;
      got.last       = rsp_ch.last;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result handle %h length %0d",
                                   got.handle_out, got.length));
      end else begin
         want = expected_results.pop_front();
         if (got.status !== want.status || got.item_valid !== want.item_valid ||
             got.handle_out !== want.handle_out || got.length !== want.length ||
             got.last !== want.last)
            report_mismatch($sformatf(
               "got st %b iv %b h %h len %0d last %b, want st %b iv %b h %h len %0d last %b",
               got.status, got.item_valid, got.handle_out, got.length, got.last,
               want.status, want.item_valid, want.handle_out, want.length, want.last));
      end
   endtask

   // Result side: check accepted items and drive ready on a changing pattern.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         check_result();
      if (stall_window == 0) begin
         stall_mode   = rx_pattern_type'($urandom_range(0, 3));
         stall_window = $urandom_range(50, 200);
      end else begin
         stall_window--;
      end
      case (stall_mode)
         RX_ALWAYS:   rsp_ch.ready <= 1'b1;
         RX_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         RX_PERIODIC: rsp_ch.ready <= (stall_window % 3 != 0);
         default:     rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Pick a handle: mostly stored ones or ones from a fixed pool, some zero or random.
   function automatic logic [HANDLE_WIDTH-1:0] pick_handle;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 5)
         return '0;
      if (sel < 20)
         return HANDLE_WIDTH'($urandom);
      if (sel < 45 && stored_handles.size() != 0)
         return stored_handles[$urandom_range(0, stored_handles.size() - 1)];
      return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // Empty-queue cases, field extremes and deletion at every position.
   task automatic test_directed;
      send_item(OP_ITERATE, HANDLE_WIDTH'($urandom));
      send_item(OP_DEQUEUE, HANDLE_WIDTH'($urandom));
      send_item(OP_DELETE, 32'h0000_0005);
      send_item(OP_ENQUEUE, '0);
      send_item(OP_ENQUEUE, 32'hFFFF_FFFF);
      send_item(OP_ENQUEUE, 32'h0000_0001);
      send_item(OP_ENQUEUE, 32'h8000_0000);
      send_item(OP_ENQUEUE, 32'h5555_5555);
      send_item(OP_ENQUEUE, 32'hAAAA_AAAA);
      send_item(OP_DELETE, '0);
      send_item(OP_DELETE, 32'h0000_0002);
      send_item(OP_ITERATE, '0);
      // Removing the newest entry must pull the back of the queue in.
      send_item(OP_DELETE, 32'hAAAA_AAAA);
      send_item(OP_ENQUEUE, 32'h7FFF_FFFF);
      send_item(OP_ITERATE, 32'hFFFF_FFFF);
      send_item(OP_DELETE, 32'hFFFF_FFFF);
      send_item(OP_DELETE, 32'h8000_0000);
      send_item(OP_DEQUEUE, '0);
      send_item(OP_DEQUEUE, 32'hFFFF_FFFF);
      send_item(OP_DEQUEUE, '0);
      send_item(OP_DEQUEUE, '0);
      send_item(OP_ITERATE, '0);
   endtask

   // Fill to capacity, overflow, and wrap the store around.
   task automatic test_full_queue;
      for (int i = 0; i < DEPTH; i++)
         send_item(OP_ENQUEUE, handle_pool[$urandom_range(0, POOL_SIZE - 1)]);
      send_item(OP_ENQUEUE, handle_pool[0]);
      send_item(OP_ITERATE, '0);
      send_item(OP_DELETE, stored_handles[DEPTH / 2]);
      send_item(OP_ENQUEUE, 32'hDEAD_0001);
      for (int i = 0; i < 5; i++)
         send_item(OP_DEQUEUE, '0);
      for (int i = 0; i < 5; i++)
         send_item(OP_ENQUEUE, HANDLE_WIDTH'($urandom_range(1, 1000)));
      send_item(OP_ITERATE, '0);
      send_item(OP_DELETE, stored_handles[stored_handles.size() - 1]);
      send_item(OP_DELETE, stored_handles[0]);
      send_item(OP_ITERATE, '0);
      // Let the block run dry before the random part.
      wait_for_results();
   endtask

   // Random operations in alternating fill and drain phases.
   task automatic test_random;
      bit     filling;
      int     phase_left;
      int     sel;
      op_type op;
      filling    = 1'b1;
      phase_left = $urandom_range(15, 40);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            filling    = !filling;
            phase_left = $urandom_range(15, 40);
         end
         phase_left--;
         sel = $urandom_range(0, 99);
         if (filling)
            op = (sel < 55) ? OP_ENQUEUE : (sel < 70) ? OP_DEQUEUE :
                 (sel < 88) ? OP_DELETE  : OP_ITERATE;
         else
            op = (sel < 20) ? OP_ENQUEUE : (sel < 55) ? OP_DEQUEUE :
                 (sel < 85) ? OP_DELETE  : OP_ITERATE;
         send_item(op, pick_handle());
         if (n == RANDOM_ITEMS / 2)
            wait_for_results();
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_ENQUEUE;
      req_ch.handle    <= '0;
      foreach (handle_pool[i])
         do handle_pool[i] = HANDLE_WIDTH'($urandom);
         while (handle_pool[i] == '0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_queue();
      test_random();
      wait_for_results();

      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
